// ===== rtl/cdad_pkg.sv =====
// Shared types, constants and calendar functions for the date keeper.
package cdad_pkg;

  // Request kinds carried in req_type.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_ADD  = 1'b1;

  // Calendar constants.
  localparam int unsigned MONTHS_PER_YEAR = 12;
  localparam int unsigned FEB_LEAP_DAYS   = 29;
  localparam int unsigned CENTURY         = 100;
  localparam int unsigned LEAP_CYCLE      = 400;

  // Field widths.
  localparam int unsigned YEAR_W  = 16;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned INC_W   = 16;
  localparam int unsigned REM_W   = 9;   // holds 0..399

  // Year / 400 is taken as (year / 16) / 25; the division by 25 multiplies by
  // 2^17 / 25 rounded up, which is exact for every 12-bit dividend.
  localparam int unsigned DIV16_SHIFT = 4;
  localparam int unsigned RECIP_25    = 5243;
  localparam int unsigned RECIP_SHIFT = 17;
  localparam int unsigned PROD_W      = 25;
  localparam int unsigned QUOT_W      = 8;   // the quotient is at most 163

  localparam logic [YEAR_W-1:0] YEAR_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ADD,
    ST_DONE
  } cdad_state_e;

  // Leap test from the two low year bits and the year modulo 400.
  function automatic logic is_leap(input logic [1:0] year_lo, input logic [REM_W-1:0] r400);
    logic century;
    century = (r400 == REM_W'(CENTURY)) || (r400 == REM_W'(2 * CENTURY)) ||
              (r400 == REM_W'(3 * CENTURY));
    return (year_lo == 2'd0) && !century;
  endfunction

  // Month length; an invalid month gives zero so that no day fits.
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                      len = 5'd30;
      4'd2:    len = leap ? DAY_W'(FEB_LEAP_DAYS) : 5'd28;
      default: len = '0;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/cdad_if.sv =====
// Request and response channel interfaces of the date keeper.
interface cdad_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] new_year;
  logic [3:0]  new_month;
  logic [4:0]  new_day;
  logic [15:0] day_increment;

  modport source (output valid, req_type, new_year, new_month, new_day, day_increment,
                  input ready);
  modport sink (input valid, req_type, new_year, new_month, new_day, day_increment,
                output ready);
endinterface

interface cdad_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] cur_year;
  logic [3:0]  cur_month;
  logic [4:0]  cur_day;
  logic        load_error;
  logic        year_wrapped;

  modport source (output valid, cur_year, cur_month, cur_day, load_error, year_wrapped,
                  input ready);
  modport sink (input valid, cur_year, cur_month, cur_day, load_error, year_wrapped,
                output ready);
endinterface

// ===== rtl/cdad_rem_unit.sv =====
// Two-stage unit that reduces a year modulo 400 by reciprocal multiplication.
module cdad_rem_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [cdad_pkg::YEAR_W-1:0]     year_i,
  output logic                            done_o,
  output logic [cdad_pkg::REM_W-1:0]      rem_o
);

  logic                              stage_q;
  logic                              done_q;
  logic [cdad_pkg::YEAR_W-1:0]       year_q;
  logic [cdad_pkg::QUOT_W-1:0]       quot_q, quot_d;
  logic [cdad_pkg::REM_W-1:0]        rem_q, rem_d;
  logic [cdad_pkg::PROD_W-1:0]       prod;
  logic [cdad_pkg::YEAR_W-1:0]       back;

  // First stage: the quotient by 400, dividing by 16 with a shift and by 25 with a multiply.
  assign prod   = cdad_pkg::PROD_W'(year_i[cdad_pkg::YEAR_W-1:cdad_pkg::DIV16_SHIFT]) *
                  cdad_pkg::PROD_W'(cdad_pkg::RECIP_25);
  assign quot_d = prod[cdad_pkg::PROD_W-1:cdad_pkg::RECIP_SHIFT];

  // Second stage: take the quotient times 400 back off the year.
  assign back  = cdad_pkg::YEAR_W'(quot_q) * cdad_pkg::YEAR_W'(cdad_pkg::LEAP_CYCLE);
  assign rem_d = cdad_pkg::REM_W'(year_q - back);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      stage_q <= start_i;
      done_q  <= stage_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      year_q <= year_i;
      quot_q <= quot_d;
    end
    if (stage_q) begin
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/calendar_date_add_days.sv =====
// Gregorian date keeper: a load request sets the date after a validity check,
// and an add request advances it by a day count, one month per cycle. An add
// steps across each month boundary in its way and then writes the response;
// a load passes the year through the pipelined modulo-400 unit that feeds the
// leap test, checks the date and then writes the response. One request is
// worked on at a time; the finished response sits in an output register, and
// the block takes the next request while that response waits to be taken. A
// response still waiting there holds the next one back in its final cycle
// until it is taken.
module calendar_date_add_days (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdad_req_if.sink   req_i,
  cdad_rsp_if.source rsp_o
);

  cdad_pkg::cdad_state_e state_q, state_d;

  // Architectural date, plus the year modulo 400 for the leap test.
  logic [cdad_pkg::YEAR_W-1:0]  year_q, year_d;
  logic [cdad_pkg::MONTH_W-1:0] month_q, month_d;
  logic [cdad_pkg::DAY_W-1:0]   day_q, day_d;
  logic [cdad_pkg::REM_W-1:0]   r400_q, r400_d;

  // Latched request fields and the running day count.
  logic [cdad_pkg::YEAR_W-1:0]  ld_year_q, ld_year_d;
  logic [cdad_pkg::MONTH_W-1:0] ld_month_q, ld_month_d;
  logic [cdad_pkg::DAY_W-1:0]   ld_day_q, ld_day_d;
  logic [cdad_pkg::INC_W-1:0]   inc_q, inc_d;
  logic                         err_q, err_d;
  logic                         wrap_q, wrap_d;

  // Response register.
  logic                         out_valid_q, out_valid_d;
  logic [cdad_pkg::YEAR_W-1:0]  out_year_q, out_year_d;
  logic [cdad_pkg::MONTH_W-1:0] out_month_q, out_month_d;
  logic [cdad_pkg::DAY_W-1:0]   out_day_q, out_day_d;
  logic                         out_err_q, out_err_d;
  logic                         out_wrap_q, out_wrap_d;

  logic                         req_accept;
  logic                         rem_start;
  logic                         rem_done;
  logic [cdad_pkg::REM_W-1:0]   rem_val;

  logic [cdad_pkg::DAY_W-1:0]   cur_len;
  logic [cdad_pkg::DAY_W-1:0]   ld_len;
  logic [cdad_pkg::INC_W:0]     day_sum;
  logic                         ld_ok;

  assign req_i.ready = (state_q == cdad_pkg::ST_IDLE);
  assign req_accept  = req_i.valid && req_i.ready;
  assign rem_start   = req_accept && (req_i.req_type == cdad_pkg::REQ_LOAD);

  cdad_rem_unit u_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rem_start),
    .year_i  (req_i.new_year),
    .done_o  (rem_done),
    .rem_o   (rem_val)
  );

  // Month length of the current date and of the date being loaded.
  assign cur_len = cdad_pkg::month_days(month_q, cdad_pkg::is_leap(year_q[1:0], r400_q));
  assign ld_len  = cdad_pkg::month_days(ld_month_q,
                                        cdad_pkg::is_leap(ld_year_q[1:0], rem_val));
  assign ld_ok   = (ld_day_q != '0) && (ld_day_q <= ld_len);
  assign day_sum = (cdad_pkg::INC_W+1)'(day_q) + (cdad_pkg::INC_W+1)'(inc_q);

  // Sequencer: dispatch, load check, month stepping and response write.
  always_comb begin
    state_d     = state_q;
    year_d      = year_q;
    month_d     = month_q;
    day_d       = day_q;
    r400_d      = r400_q;
    ld_year_d   = ld_year_q;
    ld_month_d  = ld_month_q;
    ld_day_d    = ld_day_q;
    inc_d       = inc_q;
    err_d       = err_q;
    wrap_d      = wrap_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_year_d  = out_year_q;
    out_month_d = out_month_q;
    out_day_d   = out_day_q;
    out_err_d   = out_err_q;
    out_wrap_d  = out_wrap_q;

    case (state_q)
      cdad_pkg::ST_IDLE: begin
        if (req_accept) begin
          ld_year_d  = req_i.new_year;
          ld_month_d = req_i.new_month;
          ld_day_d   = req_i.new_day;
          inc_d      = req_i.day_increment;
          err_d      = 1'b0;
          wrap_d     = 1'b0;
          state_d    = (req_i.req_type == cdad_pkg::REQ_LOAD) ? cdad_pkg::ST_LOAD
                                                               : cdad_pkg::ST_ADD;
        end
      end
      cdad_pkg::ST_LOAD: begin
        if (rem_done) begin
          if (ld_ok) begin
            year_d  = ld_year_q;
            month_d = ld_month_q;
            day_d   = ld_day_q;
            r400_d  = rem_val;
          end else begin
            err_d = 1'b1;
          end
          state_d = cdad_pkg::ST_DONE;
        end
      end
      cdad_pkg::ST_ADD: begin
        if (day_sum > (cdad_pkg::INC_W+1)'(cur_len)) begin
          // Spend the rest of this month and move to the first of the next.
          inc_d = cdad_pkg::INC_W'(day_sum - (cdad_pkg::INC_W+1)'(cur_len) -
                                   (cdad_pkg::INC_W+1)'(1));
          day_d = cdad_pkg::DAY_W'(1);
          if (month_q == cdad_pkg::MONTH_W'(cdad_pkg::MONTHS_PER_YEAR)) begin
            month_d = cdad_pkg::MONTH_W'(1);
            if (year_q == cdad_pkg::YEAR_MAX) begin
              year_d = '0;
              r400_d = '0;
              wrap_d = 1'b1;
            end else begin
              year_d = year_q + 1'b1;
              if (r400_q == cdad_pkg::REM_W'(cdad_pkg::LEAP_CYCLE - 1)) begin
                r400_d = '0;
              end else begin
                r400_d = r400_q + 1'b1;
              end
            end
          end else begin
            month_d = month_q + 1'b1;
          end
        end else begin
          day_d   = cdad_pkg::DAY_W'(day_sum);
          state_d = cdad_pkg::ST_DONE;
        end
      end
      cdad_pkg::ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_year_d  = year_q;
          out_month_d = month_q;
          out_day_d   = day_q;
          out_err_d   = err_q;
          out_wrap_d  = wrap_q;
          state_d     = cdad_pkg::ST_IDLE;
        end
      end
      default: state_d = cdad_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cdad_pkg::ST_IDLE;
      year_q      <= '0;
      month_q     <= cdad_pkg::MONTH_W'(1);
      day_q       <= cdad_pkg::DAY_W'(1);
      r400_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      year_q      <= year_d;
      month_q     <= month_d;
      day_q       <= day_d;
      r400_q      <= r400_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ld_year_q   <= ld_year_d;
    ld_month_q  <= ld_month_d;
    ld_day_q    <= ld_day_d;
    inc_q       <= inc_d;
    err_q       <= err_d;
    wrap_q      <= wrap_d;
    out_year_q  <= out_year_d;
    out_month_q <= out_month_d;
    out_day_q   <= out_day_d;
    out_err_q   <= out_err_d;
    out_wrap_q  <= out_wrap_d;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.cur_year     = out_year_q;
  assign rsp_o.cur_month    = out_month_q;
  assign rsp_o.cur_day      = out_day_q;
  assign rsp_o.load_error   = out_err_q;
  assign rsp_o.year_wrapped = out_wrap_q;

endmodule

// ===== rtl/cdad_checker.sv =====
// Port-level checks for the date keeper and their binding to the top level.
module cdad_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [15:0] cur_year_i,
  input logic [3:0]  cur_month_i,
  input logic [4:0]  cur_day_i,
  input logic        load_error_i,
  input logic        year_wrapped_i
);

  // A request in flight blocks the next one.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while the previous one was still in work");

  // A waiting response holds its value.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(cur_year_i) &&
      $stable(cur_month_i) && $stable(cur_day_i) && $stable(load_error_i) &&
      $stable(year_wrapped_i))
    else $error("response changed before it was taken");

  // The reported date is always a real month and a nonzero day.
  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (cur_month_i >= 4'd1) && (cur_month_i <= 4'd12) && (cur_day_i != 5'd0))
    else $error("response carries an impossible date");

  // A load cannot wrap the year and an add cannot fail a load check.
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(load_error_i && year_wrapped_i))
    else $error("both load_error and year_wrapped are set");

endmodule

bind calendar_date_add_days cdad_checker u_cdad_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .cur_year_i     (rsp_o.cur_year),
  .cur_month_i    (rsp_o.cur_month),
  .cur_day_i      (rsp_o.cur_day),
  .load_error_i   (rsp_o.load_error),
  .year_wrapped_i (rsp_o.year_wrapped)
);
